>>> design/mwssd_pkg.sv
// Package: payload types, queue entry and constants of the weighted SSD patch cost block.
package mwssd_pkg;

    localparam int PIXEL_W        = 8;
    localparam int SLICE_W        = 3;
    localparam int SLOT_W         = 16;
    localparam int WEIGHT_W       = 16;
    localparam int SQUARE_W       = 2 * PIXEL_W;
    localparam int PRODUCT_W      = SQUARE_W + WEIGHT_W;
    localparam int COST_W         = 44;
    localparam int SUM_W          = COST_W + 1;
    localparam int NUM_WEIGHTS    = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = WEIGHT_W;
    localparam int DEFAULT_SLICES = 8;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;
    localparam logic [COST_W-1:0]   COST_MAX     = {COST_W{1'b1}};

    // One input transaction.
    typedef struct packed {
        logic [PIXEL_W-1:0] target_pixel;
        logic [PIXEL_W-1:0] candidate_pixel;
        logic               skip;
        logic [SLICE_W-1:0] slice;
        logic [SLOT_W-1:0]  slot;
        logic               last;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [SLOT_W-1:0] result_slot;
        logic [COST_W-1:0] cost;
    } t_out_item;

    // Classified pixel handed from front to back.
    typedef struct packed {
        logic [PIXEL_W-1:0]  diff;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
        logic [SLOT_W-1:0]   slot;
    } t_work;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> design/masked_weighted_ssd_patch_cost.sv
// Top level: masked weighted sum of squared differences over a candidate patch.
//
// Usage: pixel pairs enter on the input channel (i_in_valid / o_in_stall,
// payload i_in_item), one transaction per cycle at full rate. Each pixel not
// skipped and with a slice below SLICES adds |target - candidate|^2 times the
// Q8.8 weight of its slice to a running sum (8 fraction bits, clamped at
// 2^44 - 1). The transaction with last set adds its own pixel, then sends
// the sum with its slot on the output channel (o_out_valid / i_out_stall,
// payload o_out_item) and clears the sum.
// Weights are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle;
// reset sets every weight to 1.0 and clears the sum and all valid state.
// A result passes the queue, square stage, weight stage and result register
// after the edge that accepts the last pixel.
// Throughput: 1 pixel per cycle, set by one multiplier in each of the square
// and weight stages. While a held result is stalled, the back pipe holds and
// the front takes pixels until the 4-entry queue fills, then raises o_in_stall.
module masked_weighted_ssd_patch_cost
    import mwssd_pkg::*;
#(
    parameter int SLICES      = DEFAULT_SLICES,
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    logic      push;
    logic      pop;
    t_work     front_work;
    t_work     back_work;
    t_q_status q_status;

    mwssd_front #(
        .SLICES (SLICES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_status (q_status),
        .o_push     (push),
        .o_work     (front_work)
    );

    mwssd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_work   (front_work),
        .i_pop    (pop),
        .o_work   (back_work),
        .o_status (q_status)
    );

    mwssd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_work      (back_work),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> design/mwssd_front.sv
// Front end: holds the slice weights, accepts pixels and classifies them for the queue.
module mwssd_front
    import mwssd_pkg::*;
#(
    parameter int SLICES = DEFAULT_SLICES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    input  t_q_status             i_q_status,
    output logic                  o_push,
    output t_work                 o_work
);

    logic [WEIGHT_W-1:0] r_weight [SLICES];
    logic [WEIGHT_W-1:0] sel_weight;
    logic [PIXEL_W-1:0]  diff;

    // Write weights; indexes at or above SLICES are dropped.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SLICES; k++) begin
            if (!i_rst_n) begin
                r_weight[k] <= WEIGHT_RESET;
            end else if (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(k))) begin
                r_weight[k] <= i_cfg_data;
            end
        end
    end

    // Pick the weight; skipped or out-of-range pixels weigh zero.
    always_comb begin
        sel_weight = '0;
        if (!i_in_item.skip) begin
            for (int k = 0; k < SLICES; k++) begin
                if (i_in_item.slice == SLICE_W'(k)) begin
                    sel_weight = r_weight[k];
                end
            end
        end
    end

    // Absolute difference of the pixel pair.
    assign diff = (i_in_item.target_pixel >= i_in_item.candidate_pixel)
                ? (i_in_item.target_pixel - i_in_item.candidate_pixel)
                : (i_in_item.candidate_pixel - i_in_item.target_pixel);

    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    always_comb begin
        o_work.diff   = diff;
        o_work.weight = sel_weight;
        o_work.last   = i_in_item.last;
        o_work.slot   = i_in_item.slot;
    end

endmodule

>>> design/mwssd_queue.sv
// Short queue of classified pixels between front and back.
module mwssd_queue
    import mwssd_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_work     i_work,
    input  logic      i_pop,
    output t_work     o_work,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    // Store the pushed entry.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    // Advance pointers with wrap and track the fill level.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_work         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    // Fill level never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // A pop only happens with data present.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue popped while empty");

    // A push alone raises the count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow push");

endmodule

>>> design/mwssd_back.sv
// Back end: square, weight, accumulate with saturation and present the patch cost.
module mwssd_back
    import mwssd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q_status,
    input  t_work     i_work,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic                 adv;
    logic                 r_s1_valid;
    logic [SQUARE_W-1:0]  r_s1_square;
    logic [WEIGHT_W-1:0]  r_s1_weight;
    logic                 r_s1_last;
    logic [SLOT_W-1:0]    r_s1_slot;
    logic                 r_s2_valid;
    logic [PRODUCT_W-1:0] r_s2_product;
    logic                 r_s2_last;
    logic [SLOT_W-1:0]    r_s2_slot;
    logic [COST_W-1:0]    r_sum, n_sum;
    logic [SUM_W-1:0]     raw_sum;
    logic [COST_W-1:0]    sat_sum;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_item;

    // The whole pipe moves unless a finished result is held.
    assign adv   = !(r_out_valid && i_out_stall);
    assign o_pop = adv && !i_q_status.empty;

    // Stage one: square the difference.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_square <= SQUARE_W'(i_work.diff) * SQUARE_W'(i_work.diff);
            r_s1_weight <= i_work.weight;
            r_s1_last   <= i_work.last;
            r_s1_slot   <= i_work.slot;
        end
    end

    // Stage two: apply the slice weight.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_product <= PRODUCT_W'(r_s1_square) * PRODUCT_W'(r_s1_weight);
            r_s2_last    <= r_s1_last;
            r_s2_slot    <= r_s1_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= o_pop;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage three: accumulate and clamp at the cost range.
    assign raw_sum = {1'b0, r_sum} + SUM_W'(r_s2_product);
    assign sat_sum = raw_sum[COST_W] ? COST_MAX : raw_sum[COST_W-1:0];

    always_comb begin
        n_sum       = r_sum;
        n_out_valid = r_out_valid && i_out_stall;
        if (adv && r_s2_valid) begin
            n_sum       = r_s2_last ? '0 : sat_sum;
            n_out_valid = r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    // Load the result register on a patch end.
    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid && r_s2_last) begin
            r_out_item.result_slot <= r_s2_slot;
            r_out_item.cost        <= sat_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A patch end clears the sum and raises a result.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s2_valid && r_s2_last) |=> (r_sum == '0 && r_out_valid))
        else $error("patch end did not clear sum or raise result");

    // A held result freezes the pipe and the sum.
    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_sum) && $stable(r_s2_valid)))
        else $error("pipe moved while result held");

endmodule

>>> tb/testbench.sv
// Testbench: weighted SSD patch cost block under directed, full-scale and random patch traffic.
module testbench;
    import mwssd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLICE_COUNT   = DEFAULT_SLICES;
    localparam int SETTLE_CYCLES = 8;
    localparam int HANG_LIMIT    = 5000;
    localparam int RANDOM_ITEMS  = 230;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;

    // Shadow of the block: slice weights and the running patch cost
    bit [WEIGHT_W-1:0] slice_weight [NUM_WEIGHTS];
    bit [63:0]         patch_cost_sum;
    t_out_item         pending_costs [$];

    int send_idle_pct;
    int recv_stall_pct;
    int n_pixels;
    int n_costs;
    int n_errors;
    int quiet_cycles;

    masked_weighted_ssd_patch_cost #(
        .SLICES (SLICE_COUNT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Free-running clock, 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare each accepted cost transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item exp_cost;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_costs.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result: actual slot %0d cost %0d",
                         $time, o_out_item.result_slot, o_out_item.cost);
            end else begin
                exp_cost = pending_costs.pop_front();
                n_costs++;
                if (o_out_item.result_slot !== exp_cost.result_slot) begin
                    n_errors++;
                    $display("%0t: result_slot mismatch: expected %0d actual %0d",
                             $time, exp_cost.result_slot, o_out_item.result_slot);
                end
                if (o_out_item.cost !== exp_cost.cost) begin
                    n_errors++;
                    $display("%0t: cost mismatch (slot %0d): expected %0d actual %0d",
                             $time, exp_cost.result_slot, exp_cost.cost, o_out_item.cost);
                end
            end
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d costs outstanding",
                         $time, HANG_LIMIT, pending_costs.size());
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Add one pixel to the shadow sum; emit the patch cost on the last pixel
    function automatic void accumulate_pixel(input t_in_item px);
        bit [63:0] diff;
        bit [63:0] total;
        t_out_item res;
        if (!px.skip && int'(px.slice) < SLICE_COUNT) begin
            diff = (px.target_pixel >= px.candidate_pixel) ?
                   64'(px.target_pixel - px.candidate_pixel) :
                   64'(px.candidate_pixel - px.target_pixel);
            total = patch_cost_sum + diff * diff * 64'(slice_weight[px.slice]);
            patch_cost_sum = (total > 64'(COST_MAX)) ? 64'(COST_MAX) : total;
        end
        if (px.last) begin
            res.result_slot = px.slot;
            res.cost        = patch_cost_sum[COST_W-1:0];
            pending_costs   = {pending_costs, res};
            patch_cost_sum = '0;
        end
    endfunction

    function automatic t_in_item make_pixel(input int tgt, input int cand, input bit skip,
                                            input int slc, input int slot, input bit last);
        t_in_item px;
        px.target_pixel    = PIXEL_W'(tgt);
        px.candidate_pixel = PIXEL_W'(cand);
        px.skip            = skip;
        px.slice           = SLICE_W'(slc);
        px.slot            = SLOT_W'(slot);
        px.last            = last;
        return px;
    endfunction

    // Random pixel value, biased toward the range ends
    function automatic int rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Drive one pixel transaction and hold it until accepted
    task automatic send_pixel(input t_in_item px);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= px;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        accumulate_pixel(px);
        n_pixels++;
    endtask

    // Hold the sender until every predicted cost has arrived, then let the pipe empty
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all weights; call only while the block is idle
    task automatic write_weights(input bit [WEIGHT_W-1:0] w [NUM_WEIGHTS]);
        for (int i = 0; i < NUM_WEIGHTS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= w[i];
            @(posedge i_clk);
            slice_weight[i] = w[i];
        end
        i_cfg_we <= 1'b0;
    endtask

    // Reset weights: extreme differences, skipped last pixel, every slice
    task automatic test_unit_weights();
        send_pixel(make_pixel(255, 0, 1'b0, 0, 16'h0001, 1'b1));
        send_pixel(make_pixel(0, 255, 1'b0, 3, 16'hFFFF, 1'b1));
        send_pixel(make_pixel(77, 77, 1'b0, 5, 16'h0000, 1'b1));
        send_pixel(make_pixel(255, 0, 1'b1, 2, 16'h8000, 1'b1));
        for (int s = 0; s < NUM_WEIGHTS; s++) begin
            send_pixel(make_pixel(s * 30, 255 - s * 20, s == 4, s, 16'h1234 + s,
                                  s == NUM_WEIGHTS - 1));
        end
        send_pixel(make_pixel(0, 255, 1'b1, 6, 16'h00AA, 1'b0));
        send_pixel(make_pixel(10, 3, 1'b0, 1, 16'h5555, 1'b1));
        drain_results();
    endtask

    // Zero, full-scale and odd weights, one patch per slice
    task automatic test_weight_extremes();
        bit [WEIGHT_W-1:0] w [NUM_WEIGHTS];
        w = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0100, 16'h8000, 16'hFFFF, 16'h0000, 16'h00FF};
        write_weights(w);
        for (int s = 0; s < NUM_WEIGHTS; s++) begin
            send_pixel(make_pixel(255, 0, 1'b0, s, 16'hA000 + s, 1'b1));
        end
        send_pixel(make_pixel(0, 255, 1'b0, 1, 16'h0F0F, 1'b0));
        send_pixel(make_pixel(200, 1, 1'b0, 7, 16'hF0F0, 1'b1));
        drain_results();
    endtask

    // Full-scale weights with maximum differences over long patches
    task automatic test_full_scale_cost();
        bit [WEIGHT_W-1:0] w [NUM_WEIGHTS];
        for (int i = 0; i < NUM_WEIGHTS; i++) w[i] = 16'hFFFF;
        write_weights(w);
        for (int i = 0; i < 48; i++) begin
            send_pixel(make_pixel(255, 0, 1'b0, i % NUM_WEIGHTS, 16'hBEEF, i == 47));
        end
        for (int i = 0; i < 32; i++) begin
            send_pixel(make_pixel(0, 255, 1'b0, 7, 16'hCAFE, i == 31));
        end
        send_pixel(make_pixel(1, 0, 1'b0, 0, 16'h0002, 1'b1));
        drain_results();
    endtask

    // Random patches of random length under one idle and stall mix
    task automatic test_random_patches(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int sent;
        int len;
        int skip_pct;
        int slot;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            case ($urandom_range(0, 5))
                0:       skip_pct = 0;
                1:       skip_pct = 100;
                default: skip_pct = 25;
            endcase
            for (int i = 0; i < len; i++) begin
                slot = $urandom_range(0, 65535);
                send_pixel(make_pixel(rand_pixel(), rand_pixel(),
                                      $urandom_range(0, 99) < skip_pct,
                                      $urandom_range(0, 7), slot, i == len - 1));
                sent++;
            end
            // Now and then hold the sender until the pipe is empty
            if ($urandom_range(0, 29) == 0) drain_results();
        end
        drain_results();
    endtask

    task automatic write_random_weights(input int max_weight);
        bit [WEIGHT_W-1:0] w [NUM_WEIGHTS];
        for (int i = 0; i < NUM_WEIGHTS; i++) w[i] = WEIGHT_W'($urandom_range(0, max_weight));
        write_weights(w);
    endtask

    initial begin
        bit [WEIGHT_W-1:0] w [NUM_WEIGHTS];
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= '0;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_in_item      <= '0;
        i_out_stall    <= 1'b0;
        quiet_cycles   = 0;
        n_pixels       = 0;
        n_costs        = 0;
        n_errors       = 0;
        patch_cost_sum = '0;
        for (int i = 0; i < NUM_WEIGHTS; i++) slice_weight[i] = WEIGHT_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 30;
        recv_stall_pct = 79;
        test_unit_weights();
        test_weight_extremes();
        test_full_scale_cost();

        write_random_weights(65535);
        test_random_patches(RANDOM_ITEMS, 30, 79);

        for (int i = 0; i < NUM_WEIGHTS; i++) w[i] = (i % 2 == 0) ? 16'hFFFF : 16'h0000;
        write_weights(w);
        test_random_patches(RANDOM_ITEMS, 79, 30);

        write_random_weights(1023);
        test_random_patches(RANDOM_ITEMS, 0, 0);

        if (pending_costs.size() != 0) begin
            n_errors++;
            $display("%0t: %0d predicted costs never arrived", $time, pending_costs.size());
        end
        $display("Run covered %0d pixel transactions and %0d patch costs", n_pixels, n_costs);
        $display("under reset, extreme and random weights, full-scale sums and three stall mixes");
        if (n_errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d errors", n_errors);
            $display("testbench failed");
        end
        $finish;
    end

endmodule
